// File: hdl/cssl_pkg.sv
package cssl_pkg;

   localparam int RING_DEPTH_DEFAULT = 256;

   localparam logic [9:0] TIMEOUT_RESET = 10'd100;
   localparam logic [7:0] CTRL_LIMIT    = 8'd32;

   // frame positions: idle, start, data bits 7..0, parity, verdict, stop
   localparam logic signed [4:0] SLOT_IDLE    = 5'sd9;
   localparam logic signed [4:0] SLOT_START   = 5'sd8;
   localparam logic signed [4:0] SLOT_MSB     = 5'sd7;
   localparam logic signed [4:0] SLOT_LSB     = 5'sd0;
   localparam logic signed [4:0] SLOT_PARITY  = -5'sd1;
   localparam logic signed [4:0] SLOT_VERDICT = -5'sd2;
   localparam logic signed [4:0] SLOT_STOP    = -5'sd3;
   localparam logic signed [4:0] SLOT_WRAP    = -5'sd4;

   // register indexes
   localparam logic CSR_LINK_ENABLE = 1'b0;
   localparam logic CSR_BIT_TIMEOUT = 1'b1;

   typedef struct packed {
      logic       func;
      logic       clock_level;
      logic       line_in;
      logic [9:0] gap_ms;
      logic [7:0] host_byte;
   } req_type;

   typedef struct packed {
      logic       line_out;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_parity_bad;
      logic       framing_bad;
      logic       push_taken;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_IDLE,
      CMD_PUSH,
      CMD_EDGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         clock_level;
      logic         line_in;
      logic         timed_out;
      logic [7:0]   host_byte;
   } cmd_type;

endpackage

// File: hdl/clocked_serial_slave_link.sv
// A pushed word is stored in the command queue, then in the rsp_ result queue.
// Throughput: one word per cycle on both sides unless a queue stalls; the slot
// engine and the ring memory (one read or one write port use per word) each
// serve a word when popped. Both sides stall on their own via two-entry queues.
// Reset (synchronous, active high): queues empty, link disabled, timeout 100,
// frame idle, ring empty; ring memory contents are not cleared.
module clocked_serial_slave_link #(
   parameter int RING_DEPTH = cssl_pkg::RING_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [9:0]        csr_wdata,
   // input words
   input  logic              req_push,
   input  cssl_pkg::req_type req_data,
   output logic              full,
   // result words
   input  logic              pop,
   output cssl_pkg::rsp_type rsp_data,
   output logic              empty
);
   import cssl_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // front -> command queue
   logic            cmd_push;
   cmd_type         cmd_front;
   logic            cmd_full;
   logic            ring_clear;
   // command queue -> back
   logic [CMD_W-1:0] cmd_q;
   logic            cmd_empty;
   logic            cmd_pop;
   // back -> result queue
   rsp_type         rsp_back;
   logic            rsp_push;
   logic            rsp_full;
   logic [RSP_W-1:0] rsp_q;

   assign full     = cmd_full;
   assign rsp_data = rsp_type'(rsp_q);

   // front: register file and word classification
   cssl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_push   (req_push),
      .req_data   (req_data),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_front),
      .ring_clear (ring_clear)
   );

   cssl_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (CMD_W'(cmd_front)),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_q),
      .empty     (cmd_empty)
   );

   // back: slot engine and transmit ring
   cssl_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ring_clear (ring_clear),
      .cmd_data   (cmd_type'(cmd_q)),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_back)
   );

   cssl_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (RSP_W'(rsp_back)),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_q),
      .empty     (empty)
   );

endmodule

// File: hdl/cssl_queue.sv
module cssl_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_in    = wr_ff ^ do_push;
      rd_in    = rd_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/cssl_front.sv
module cssl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [9:0]        csr_wdata,
   input  logic              req_push,
   input  cssl_pkg::req_type req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output cssl_pkg::cmd_type cmd_data,
   output logic              ring_clear
);
   import cssl_pkg::*;

   logic       enable_ff, enable_in;
   logic [9:0] timeout_ff, timeout_in;

   always_comb begin
      enable_in  = enable_ff;
      timeout_in = timeout_ff;
      ring_clear = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_LINK_ENABLE: begin
               enable_in  = csr_wdata[0];
               ring_clear = (csr_wdata[0] != enable_ff);
            end
            CSR_BIT_TIMEOUT: timeout_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         enable_ff  <= enable_in;
         timeout_ff <= timeout_in;
      end
   end

   // classify the word before it enters the command queue
   always_comb begin
      cmd_push             = req_push & ~cmd_full;
      cmd_data.clock_level = req_data.clock_level;
      cmd_data.line_in     = req_data.line_in;
      cmd_data.host_byte   = req_data.host_byte;
      cmd_data.timed_out   = (req_data.gap_ms > timeout_ff);
      if (!enable_ff) begin
         cmd_data.kind = CMD_IDLE;
      end else if (req_data.func) begin
         cmd_data.kind = CMD_PUSH;
      end else begin
         cmd_data.kind = CMD_EDGE;
      end
   end

endmodule

// File: hdl/cssl_back.sv
module cssl_back #(
   parameter int RING_DEPTH = cssl_pkg::RING_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ring_clear,
   input  cssl_pkg::cmd_type cmd_data,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output cssl_pkg::rsp_type rsp_data
);
   import cssl_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   logic [7:0] ring_mem [RING_DEPTH];

   logic signed [4:0] slot_ff, slot_in;
   logic [7:0]        txb_ff, txb_in;
   logic [7:0]        rxs_ff, rxs_in;
   logic              txpar_ff, txpar_in;
   logic              rxpar_ff, rxpar_in;
   logic              lerr_ff, lerr_in;
   logic              rerr_ff, rerr_in;
   logic              ferr_ff, ferr_in;
   logic              out_ff, out_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic              pend_ff, pend_in;
   logic [7:0]        rd_ff;

   logic              go;
   logic              mem_re, mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [PTR_W-1:0]  head_next, head_prev, tail_next;
   logic [7:0]        txb_eff;
   logic signed [4:0] base, dec;
   logic              ferr_now;

   assign go      = ~cmd_empty & ~rsp_full;
   assign cmd_pop = go;
   assign rsp_push = go;

   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? PTR_LAST : head_ff - 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;

   // byte fetched at frame start is taken from the read register while pend_ff is set
   assign txb_eff = pend_ff ? rd_ff : txb_ff;

   always_comb begin
      slot_in   = slot_ff;
      txb_in    = txb_eff;
      rxs_in    = rxs_ff;
      txpar_in  = txpar_ff;
      rxpar_in  = rxpar_ff;
      lerr_in   = lerr_ff;
      rerr_in   = rerr_ff;
      ferr_in   = ferr_ff;
      out_in    = out_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      pend_in   = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = tail_ff;
      ferr_now  = 1'b0;
      base      = cmd_data.timed_out ? SLOT_IDLE : slot_ff;
      dec       = base - 5'sd1;
      if (dec <= SLOT_WRAP) begin
         dec = SLOT_START;
      end

      rsp_data.rx_valid      = 1'b0;
      rsp_data.rx_byte       = 8'd0;
      rsp_data.rx_parity_bad = 1'b0;
      rsp_data.framing_bad   = 1'b0;
      rsp_data.push_taken    = 1'b0;

      if (go) begin
         case (cmd_data.kind)
            CMD_PUSH: begin
               if (cmd_data.host_byte != 8'd0 && tail_next != head_ff) begin
                  mem_we = 1'b1;
                  rsp_data.push_taken = 1'b1;
                  // control codes jump the queue when bytes are waiting
                  if (cmd_data.host_byte < CTRL_LIMIT && head_ff != tail_ff) begin
                     head_in   = head_prev;
                     mem_waddr = head_prev;
                  end else begin
                     tail_in = tail_next;
                  end
               end
            end
            CMD_EDGE: begin
               if (!cmd_data.clock_level) begin
                  slot_in = dec;
                  if (dec == SLOT_START) begin
                     if (!rerr_ff) begin
                        if (head_ff != tail_ff) begin
                           mem_re  = 1'b1;
                           pend_in = 1'b1;
                           head_in = head_next;
                        end else begin
                           txb_in = 8'd0;
                        end
                     end
                     txpar_in = 1'b0;
                     rxpar_in = 1'b0;
                     lerr_in  = 1'b0;
                     rerr_in  = 1'b0;
                     ferr_in  = 1'b0;
                     out_in   = 1'b0;
                  end else if (dec >= SLOT_LSB && dec <= SLOT_MSB) begin
                     out_in   = txb_eff[dec[2:0]];
                     txpar_in = txpar_ff ^ txb_eff[dec[2:0]];
                  end else if (dec == SLOT_PARITY) begin
                     out_in = txpar_ff;
                  end else if (dec == SLOT_VERDICT) begin
                     out_in = lerr_ff;
                  end else if (dec == SLOT_STOP) begin
                     out_in = 1'b0;
                  end
               end else begin
                  slot_in = base;
                  if (base == SLOT_START) begin
                     if (cmd_data.line_in) begin
                        ferr_in = 1'b1;
                        slot_in = SLOT_IDLE;
                        rsp_data.framing_bad = 1'b1;
                     end
                  end else if (base >= SLOT_LSB && base <= SLOT_MSB) begin
                     rxpar_in = rxpar_ff ^ cmd_data.line_in;
                     rxs_in[base[2:0]] = cmd_data.line_in;
                  end else if (base == SLOT_PARITY) begin
                     if (rxpar_ff != cmd_data.line_in) begin
                        lerr_in = 1'b1;
                     end
                  end else if (base == SLOT_VERDICT) begin
                     if (cmd_data.line_in) begin
                        rerr_in = 1'b1;
                     end
                  end else if (base == SLOT_STOP) begin
                     ferr_now = ferr_ff | cmd_data.line_in;
                     ferr_in  = ferr_now;
                     if (ferr_now) begin
                        rsp_data.framing_bad = 1'b1;
                     end else if (lerr_ff) begin
                        rsp_data.rx_parity_bad = 1'b1;
                     end else if (rxs_ff != 8'd0) begin
                        rsp_data.rx_valid = 1'b1;
                        rsp_data.rx_byte  = rxs_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (!go) begin
         pend_in = pend_ff;
         txb_in  = txb_ff;
      end
      if (ring_clear) begin
         head_in = '0;
         tail_in = '0;
      end
      rsp_data.line_out = out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_IDLE;
         txb_ff   <= 8'd0;
         rxs_ff   <= 8'd0;
         txpar_ff <= 1'b0;
         rxpar_ff <= 1'b0;
         lerr_ff  <= 1'b0;
         rerr_ff  <= 1'b0;
         ferr_ff  <= 1'b0;
         out_ff   <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         txb_ff   <= txb_in;
         rxs_ff   <= rxs_in;
         txpar_ff <= txpar_in;
         rxpar_ff <= rxpar_in;
         lerr_ff  <= lerr_in;
         rerr_ff  <= rerr_in;
         ferr_ff  <= ferr_in;
         out_ff   <= out_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         pend_ff  <= pend_in;
      end
   end

   // transmit ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= cmd_data.host_byte;
      end
      if (mem_re) begin
         rd_ff <= ring_mem[head_ff];
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_IDLE && slot_ff >= SLOT_STOP)
      else $error("slot position out of range");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= PTR_LAST && tail_ff <= PTR_LAST)
      else $error("ring pointer out of range");

   a_fetch_at_start: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> slot_ff == SLOT_START && $past(head_ff) != $past(tail_ff))
      else $error("ring fetch outside frame start");

   a_rx_nonzero: assert property (@(posedge clock) disable iff (reset)
      go && rsp_data.rx_valid |=> rxs_ff != 8'd0 && slot_ff == SLOT_STOP)
      else $error("received word delivered outside stop slot");

endmodule
